// ----- rtl/lfuc_pkg.sv -----
// shared constants, codes and control structs for the lfu cache core
`default_nettype none
package lfuc_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CAP_W   = 5;
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;

    localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ADJ_NONE    = 2'd0,
        ADJ_TOUCH   = 2'd1,
        ADJ_REPLACE = 2'd2,
        ADJ_ADD     = 2'd3
    } t_adj;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_idx;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- rtl/lfuc_req_if.sv -----
// request channel: command, key and value with valid/ready
`default_nettype none
interface lfuc_req_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic        [lfuc_pkg::KEY_W-1:0]   key;
    logic signed [lfuc_pkg::VALUE_W-1:0] value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface
`default_nettype wire

// ----- rtl/lfuc_rsp_if.sv -----
// response channel: hit, read value and eviction report with valid/ready
`default_nettype none
interface lfuc_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [lfuc_pkg::VALUE_W-1:0] read_value;
    logic                                evicted;
    logic        [lfuc_pkg::KEY_W-1:0]   evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface
`default_nettype wire

// ----- rtl/lfu_cache_lru_tiebreak_core.sv -----
// top level of the lfu key/value cache with lru tie-break
//
// usage:
//   i_req carries one get or put per beat (command, key, value); o_rsp returns
//   one beat per request (hit, read_value, evicted, evicted_key), in order.
//   i_cfg_we/i_cfg_wdata write the capacity register; write it only while idle.
// sequencing:
//   a request is taken in the idle cycle, then every entry is read once from
//   the entry memories, one address per cycle; the next request is taken only
//   after this beat commits. the response is registered when the beat commits.
//   recency updates of each beat are folded into the scan of the next one.
// reset:
//   clears all entry valid bits, occupancy and the response register; the
//   capacity returns to 16. no clearing pass is needed.
// stall:
//   a waiting response does not block the next request; that request's scan
//   runs and its commit waits until the response register is free.
`default_nettype none
module lfu_cache_lru_tiebreak_core #(
    parameter int ENTRIES    = lfuc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lfuc_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lfuc_pkg::CAP_W-1:0]        i_cfg_wdata,
    lfuc_req_if.sink                               i_req,
    lfuc_rsp_if.source                             o_rsp
);

    lfuc_pkg::t_dp_cmd dp_cmd;
    lfuc_pkg::t_dp_sts dp_sts;

    lfuc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    lfuc_dp #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (i_req.command),
        .i_key         (i_req.key),
        .i_value       (i_req.value),
        .o_rsp_valid   (o_rsp.valid),
        .i_rsp_ready   (o_rsp.ready),
        .o_hit         (o_rsp.hit),
        .o_read_value  (o_rsp.read_value),
        .o_evicted     (o_rsp.evicted),
        .o_evicted_key (o_rsp.evicted_key)
    );

endmodule
`default_nettype wire

// ----- rtl/lfuc_ctrl.sv -----
// sequencer for accept, table scan, drain and commit of one beat
`default_nettype none
module lfuc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire lfuc_pkg::t_dp_sts i_sts,
    output lfuc_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.rd_en  = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = i_rst_n;
                if (i_rst_n && i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lfuc_dp.sv -----
// entry memories, scan compare, replacement decision and response register
`default_nettype none
module lfuc_dp #(
    parameter int ENTRIES    = lfuc_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lfuc_pkg::KEY_BITS_DEF,
    parameter int COUNT_BITS = lfuc_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lfuc_pkg::t_dp_cmd                   i_cmd,
    output lfuc_pkg::t_dp_sts                        o_sts,
    input  wire logic                                i_cfg_we,
    input  wire logic        [lfuc_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  wire logic                                i_command,
    input  wire logic        [lfuc_pkg::KEY_W-1:0]   i_key,
    input  wire logic signed [lfuc_pkg::VALUE_W-1:0] i_value,
    output logic                                     o_rsp_valid,
    input  wire logic                                i_rsp_ready,
    output logic                                     o_hit,
    output logic signed      [lfuc_pkg::VALUE_W-1:0] o_read_value,
    output logic                                     o_evicted,
    output logic             [lfuc_pkg::KEY_W-1:0]   o_evicted_key
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int KW = (KEY_BITS < lfuc_pkg::KEY_W) ? KEY_BITS : lfuc_pkg::KEY_W;
    localparam int CB = COUNT_BITS;
    localparam int VW = lfuc_pkg::VALUE_W;

    // entry storage
    logic [KW-1:0] r_key_mem  [ENTRIES];
    logic [VW-1:0] r_data_mem [ENTRIES];
    logic [CB-1:0] r_cnt_mem  [ENTRIES];
    logic [IW-1:0] r_rank_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    logic [OW-1:0]              r_occ;
    logic [lfuc_pkg::CAP_W-1:0] r_cap;

    // rank adjustment left over from the previous beat
    lfuc_pkg::t_adj r_pend;
    logic [IW-1:0]  r_pend_thr;
    logic [IW-1:0]  r_pend_slot;

    // current beat
    logic          r_put;
    logic [KW-1:0] r_key;
    logic [VW-1:0] r_val;
    logic [IW-1:0] r_idx;

    // read stage
    logic          r_chk;
    logic [IW-1:0] r_chk_idx;
    logic [KW-1:0] r_rd_key;
    logic [VW-1:0] r_rd_data;
    logic [CB-1:0] r_rd_cnt;
    logic [IW-1:0] r_rd_rank;

    // scan results
    logic          r_found;
    logic [IW-1:0] r_found_idx;
    logic [VW-1:0] r_found_data;
    logic [CB-1:0] r_found_cnt;
    logic [IW-1:0] r_found_rank;
    logic          r_vic_any;
    logic [IW-1:0] r_vic_idx;
    logic [KW-1:0] r_vic_key;
    logic [CB-1:0] r_vic_cnt;
    logic [IW-1:0] r_vic_rank;
    logic          r_free_any;
    logic [IW-1:0] r_free_idx;

    logic          r_out_valid;

    logic          rd_v;
    logic [IW-1:0] adj_rank;
    logic          key_match;
    logic          vic_better;

    logic [OW-1:0] cap_eff;
    logic          do_put;
    logic          touch;
    logic          ins;
    logic          evict;
    logic          ins_ok;
    logic [IW-1:0] slot;
    logic [IW-1:0] c_addr;
    logic [CB-1:0] cnt_sat;

    logic          key_we;
    logic          data_we;
    logic [VW-1:0] data_wd;
    logic          cnt_we;
    logic [CB-1:0] cnt_wd;
    logic          rank_we;
    logic [IW-1:0] rank_wa;
    logic [IW-1:0] rank_wd;

    // adjusted rank of the row under check
    always_comb begin
        adj_rank = r_rd_rank;
        if (r_chk_idx != r_pend_slot) begin
            unique case (r_pend)
                lfuc_pkg::ADJ_TOUCH: begin
                    adj_rank = (r_rd_rank < r_pend_thr) ? r_rd_rank + IW'(1) : r_rd_rank;
                end
                lfuc_pkg::ADJ_REPLACE: begin
                    adj_rank = (r_rd_rank > r_pend_thr) ? r_rd_rank : r_rd_rank + IW'(1);
                end
                lfuc_pkg::ADJ_ADD: begin
                    adj_rank = r_rd_rank + IW'(1);
                end
                lfuc_pkg::ADJ_NONE: begin
                    adj_rank = r_rd_rank;
                end
                default: begin
                    adj_rank = r_rd_rank;
                end
            endcase
        end
    end

    assign rd_v       = r_valid[r_chk_idx];
    assign key_match  = rd_v && (r_rd_key == r_key);
    assign vic_better = rd_v && (!r_vic_any || (r_rd_cnt < r_vic_cnt) ||
                                 ((r_rd_cnt == r_vic_cnt) && (adj_rank > r_vic_rank)));

    // replacement decision
    always_comb begin
        cap_eff = (32'(r_cap) >= ENTRIES) ? OW'(ENTRIES) : OW'(r_cap);
        do_put  = (r_put == lfuc_pkg::CMD_PUT) && (cap_eff != '0);
        touch   = r_found && ((r_put == lfuc_pkg::CMD_GET) || do_put);
        ins     = do_put && !r_found;
        evict   = ins && (r_occ >= cap_eff) && r_vic_any;
        ins_ok  = ins && (evict || r_free_any);
        slot    = evict ? r_vic_idx : r_free_idx;
        c_addr  = touch ? r_found_idx : slot;
        cnt_sat = (r_found_cnt == {CB{1'b1}}) ? r_found_cnt : r_found_cnt + CB'(1);
    end

    always_comb begin
        key_we  = i_cmd.commit && ins_ok;
        data_we = i_cmd.commit && (ins_ok || (touch && (r_put == lfuc_pkg::CMD_PUT)));
        data_wd = r_val;
        cnt_we  = i_cmd.commit && (ins_ok || touch);
        cnt_wd  = ins_ok ? CB'(1) : cnt_sat;
        if (i_cmd.commit && (ins_ok || touch)) begin
            rank_we = 1'b1;
            rank_wa = c_addr;
            rank_wd = '0;
        end else begin
            rank_we = r_chk;
            rank_wa = r_chk_idx;
            rank_wd = adj_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[c_addr] <= r_key;
        end
        if (i_cmd.rd_en) begin
            r_rd_key <= r_key_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            r_data_mem[c_addr] <= data_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_data_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[c_addr] <= cnt_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_cnt <= r_cnt_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            r_rank_mem[rank_wa] <= rank_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_rank <= r_rank_mem[r_idx];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_occ       <= '0;
            r_cap       <= lfuc_pkg::CAP_RESET;
            r_pend      <= lfuc_pkg::ADJ_NONE;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_chk <= i_cmd.rd_en;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (touch) begin
                    r_pend <= lfuc_pkg::ADJ_TOUCH;
                end else if (ins_ok) begin
                    r_valid[slot] <= 1'b1;
                    if (evict) begin
                        r_pend <= lfuc_pkg::ADJ_REPLACE;
                    end else begin
                        r_pend <= lfuc_pkg::ADJ_ADD;
                        r_occ  <= r_occ + OW'(1);
                    end
                end else begin
                    r_pend <= lfuc_pkg::ADJ_NONE;
                end
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // beat capture, scan and response payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_put      <= i_command;
            r_key      <= i_key[KW-1:0];
            r_val      <= i_value;
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_vic_any  <= 1'b0;
            r_free_any <= 1'b0;
        end else if (i_cmd.rd_en) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.rd_en) begin
            r_chk_idx <= r_idx;
        end
        if (r_chk) begin
            if (key_match && !r_found) begin
                r_found      <= 1'b1;
                r_found_idx  <= r_chk_idx;
                r_found_data <= r_rd_data;
                r_found_cnt  <= r_rd_cnt;
                r_found_rank <= adj_rank;
            end
            if (vic_better) begin
                r_vic_any  <= 1'b1;
                r_vic_idx  <= r_chk_idx;
                r_vic_key  <= r_rd_key;
                r_vic_cnt  <= r_rd_cnt;
                r_vic_rank <= adj_rank;
            end
            if (!rd_v && !r_free_any) begin
                r_free_any <= 1'b1;
                r_free_idx <= r_chk_idx;
            end
        end
        if (i_cmd.commit) begin
            if (touch) begin
                r_pend_thr  <= r_found_rank;
                r_pend_slot <= r_found_idx;
            end else begin
                r_pend_thr  <= r_vic_rank;
                r_pend_slot <= slot;
            end
            o_hit         <= r_found;
            o_read_value  <= ((r_put == lfuc_pkg::CMD_GET) && r_found) ?
                             r_found_data : lfuc_pkg::MISS_VALUE;
            o_evicted     <= evict;
            o_evicted_key <= evict ? lfuc_pkg::KEY_W'(r_vic_key) : '0;
        end
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_sts.last_idx = (r_idx == IW'(ENTRIES - 1));
    assign o_sts.out_free = !r_out_valid || i_rsp_ready;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the lfu cache core: directed and random gets/puts checked against a cache predictor
`timescale 1ns / 100ps
module tb;

    localparam int          NSLOTS    = lfuc_pkg::ENTRIES_DEF;
    localparam int unsigned COUNT_MAX = (1 << lfuc_pkg::COUNT_BITS_DEF) - 1;
    localparam int          SETTLE    = 2 * NSLOTS + 8;

    typedef struct packed {
        logic                                command;
        logic        [lfuc_pkg::KEY_W-1:0]   key;
        logic signed [lfuc_pkg::VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                                hit;
        logic signed [lfuc_pkg::VALUE_W-1:0] read_value;
        logic                                evicted;
        logic        [lfuc_pkg::KEY_W-1:0]   evicted_key;
    } t_rsp;

    logic                         i_clk;
    logic                         i_rst_n     = 1'b0;
    logic                         cfg_we      = 1'b0;
    logic [lfuc_pkg::CAP_W-1:0]   cfg_wdata   = '0;
    logic                         req_valid_q = 1'b0;
    t_req                         req_data_q  = '0;
    logic                         rsp_ready_q = 1'b0;

    lfuc_req_if req_if ();
    lfuc_rsp_if rsp_if ();

    assign req_if.valid   = req_valid_q;
    assign req_if.command = req_data_q.command;
    assign req_if.key     = req_data_q.key;
    assign req_if.value   = req_data_q.value;
    assign rsp_if.ready   = rsp_ready_q;

    lfu_cache_lru_tiebreak_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    // predictor state
    bit                           slot_valid [NSLOTS];
    logic [lfuc_pkg::KEY_W-1:0]   slot_key   [NSLOTS];
    logic [lfuc_pkg::VALUE_W-1:0] slot_data  [NSLOTS];
    int unsigned                  slot_uses  [NSLOTS];
    int unsigned                  slot_age   [NSLOTS];
    int unsigned                  slot_fill      = 0;
    int unsigned                  capacity_model = lfuc_pkg::CAP_RESET;

    t_req  req_backlog [$];
    t_rsp  rsp_due     [$];
    int    req_issued     = 0;
    int    req_beats      = 0;
    int    mismatch_count = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    bit    hold_go        = 0;
    bit    hold_rx        = 0;

    function automatic void bump_slot(input int s);
        int          j;
        int unsigned age;
        age = slot_age[s];
        for (j = 0; j < NSLOTS; j++) begin
            if (slot_valid[j] && slot_age[j] < age) slot_age[j]++;
        end
        slot_age[s] = 0;
        if (slot_uses[s] < COUNT_MAX) slot_uses[s]++;
    endfunction

    function automatic t_rsp predict_cache(input t_req r);
        t_rsp        e;
        int          j;
        int          found;
        int          victim;
        int          slot;
        int unsigned cap;
        int unsigned age;
        e.hit         = 1'b0;
        e.read_value  = lfuc_pkg::MISS_VALUE;
        e.evicted     = 1'b0;
        e.evicted_key = '0;
        found = -1;
        for (j = 0; j < NSLOTS; j++) begin
            if (found < 0 && slot_valid[j] && slot_key[j] == r.key) found = j;
        end
        cap = (capacity_model > NSLOTS) ? NSLOTS : capacity_model;
        if (r.command == lfuc_pkg::CMD_GET) begin
            if (found >= 0) begin
                e.read_value = slot_data[found];
                bump_slot(found);
            end
        end else if (cap != 0) begin
            if (found >= 0) begin
                slot_data[found] = r.value;
                bump_slot(found);
            end else begin
                slot = -1;
                if (slot_fill >= cap) begin
                    victim = -1;
                    for (j = 0; j < NSLOTS; j++) begin
                        if (slot_valid[j]) begin
                            if (victim < 0) victim = j;
                            else if (slot_uses[j] < slot_uses[victim] ||
                                     (slot_uses[j] == slot_uses[victim] &&
                                      slot_age[j] > slot_age[victim])) victim = j;
                        end
                    end
                    if (victim >= 0) begin
                        e.evicted     = 1'b1;
                        e.evicted_key = slot_key[victim];
                        age = slot_age[victim];
                        slot_valid[victim] = 0;
                        for (j = 0; j < NSLOTS; j++) begin
                            if (slot_valid[j] && slot_age[j] > age) slot_age[j]--;
                        end
                        if (slot_fill > 0) slot_fill--;
                        slot = victim;
                    end
                end
                for (j = 0; j < NSLOTS; j++) begin
                    if (slot < 0 && !slot_valid[j]) slot = j;
                end
                if (slot >= 0) begin
                    for (j = 0; j < NSLOTS; j++) begin
                        if (slot_valid[j]) slot_age[j]++;
                    end
                    slot_valid[slot] = 1;
                    slot_key[slot]   = r.key;
                    slot_data[slot]  = r.value;
                    slot_uses[slot]  = 1;
                    slot_age[slot]   = 0;
                    slot_fill++;
                end
            end
        end
        e.hit = (found >= 0);
        return e;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic push_request(input logic cmd, input logic [lfuc_pkg::KEY_W-1:0] key,
                                input logic [lfuc_pkg::VALUE_W-1:0] value);
        t_req r;
        r.command = cmd;
        r.key     = key;
        r.value   = value;
        req_backlog.push_back(r);
    endtask

    task automatic queue_random(input int count, input int pool_size);
        logic [lfuc_pkg::KEY_W-1:0] pool [$];
        t_req                       r;
        int                         k;
        repeat (pool_size) pool.push_back(lfuc_pkg::KEY_W'($urandom));
        for (k = 0; k < count; k++) begin
            r.command = $urandom_range(0, 1) ? lfuc_pkg::CMD_PUT : lfuc_pkg::CMD_GET;
            if ($urandom_range(0, 9) == 0) r.key = lfuc_pkg::KEY_W'($urandom);
            else r.key = pool[$urandom_range(0, pool_size - 1)];
            case ($urandom_range(0, 15))
                0:       r.value = 32'h7FFF_FFFF;
                1:       r.value = 32'h8000_0000;
                2:       r.value = lfuc_pkg::MISS_VALUE;
                default: r.value = $urandom;
            endcase
            req_backlog.push_back(r);
        end
    endtask

    task automatic drain();
        while (req_backlog.size() != 0 || req_issued != req_beats || rsp_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [lfuc_pkg::CAP_W-1:0] v);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        capacity_model = v;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // request driver
    always @(negedge i_clk) begin
        if (req_issued == req_beats) begin
            if (i_rst_n && req_backlog.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                req_data_q  <= req_backlog.pop_front();
                req_valid_q <= 1'b1;
                req_issued++;
            end else begin
                req_valid_q <= 1'b0;
            end
        end
        rsp_ready_q <= !hold_rx && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // beat monitor: checks response beats, predicts on request beats
    always @(posedge i_clk) begin : monitor
        t_rsp want;
        t_req seen;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (rsp_due.size() == 0) begin
                    report_mismatch("response beat with nothing outstanding");
                end else begin
                    want = rsp_due.pop_front();
                    if (rsp_if.hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", rsp_if.hit, want.hit));
                    if (rsp_if.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, want %h",
                                                  rsp_if.read_value, want.read_value));
                    if (rsp_if.evicted !== want.evicted)
                        report_mismatch($sformatf("evicted %b, want %b",
                                                  rsp_if.evicted, want.evicted));
                    if (rsp_if.evicted_key !== want.evicted_key)
                        report_mismatch($sformatf("evicted_key %h, want %h",
                                                  rsp_if.evicted_key, want.evicted_key));
                end
            end
            if (req_if.valid && req_if.ready) begin
                seen.command = req_if.command;
                seen.key     = req_if.key;
                seen.value   = req_if.value;
                rsp_due.push_back(predict_cache(seen));
                req_beats++;
            end
        end
    end

    // long receiver hold-off so the core backs up and stalls its request side
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_rx = 1;
        repeat (400) @(posedge i_clk);
        hold_rx = 0;
    end

    initial begin
        #1_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset capacity: key and value extremes, overwrite with all-ones value
        push_request(lfuc_pkg::CMD_GET, 16'h0000, 32'h0000_0000);
        push_request(lfuc_pkg::CMD_PUT, 16'h0000, 32'h7FFF_FFFF);
        push_request(lfuc_pkg::CMD_PUT, 16'hFFFF, 32'h8000_0000);
        push_request(lfuc_pkg::CMD_GET, 16'h0000, 32'hFFFF_FFFF);
        push_request(lfuc_pkg::CMD_GET, 16'hFFFF, 32'h0000_0000);
        push_request(lfuc_pkg::CMD_PUT, 16'h0000, lfuc_pkg::MISS_VALUE);
        push_request(lfuc_pkg::CMD_GET, 16'h0000, 32'h0000_0000);
        drain();

        // two entries: least used goes first, ties go to least recent
        write_capacity(5'd2);
        push_request(lfuc_pkg::CMD_PUT, 16'h1234, 32'h0000_0001);
        push_request(lfuc_pkg::CMD_PUT, 16'h5678, 32'h0000_0002);
        push_request(lfuc_pkg::CMD_PUT, 16'hAAAA, 32'h0000_0003);
        push_request(lfuc_pkg::CMD_GET, 16'hAAAA, 32'h0000_0000);
        push_request(lfuc_pkg::CMD_PUT, 16'h5555, 32'hDEAD_BEEF);
        drain();

        // capacity zero: puts ignored, present keys still hit
        write_capacity(5'd0);
        push_request(lfuc_pkg::CMD_PUT, 16'hAAAA, 32'h1111_1111);
        push_request(lfuc_pkg::CMD_PUT, 16'h1111, 32'h2222_2222);
        push_request(lfuc_pkg::CMD_GET, 16'hAAAA, 32'h0000_0000);
        push_request(lfuc_pkg::CMD_GET, 16'h1111, 32'h0000_0000);
        drain();

        // add six entries, then drop capacity below occupancy
        write_capacity(5'd16);
        push_request(lfuc_pkg::CMD_PUT, 16'h0101, 32'h0000_0101);
        push_request(lfuc_pkg::CMD_PUT, 16'h0202, 32'h0000_0202);
        push_request(lfuc_pkg::CMD_PUT, 16'h0404, 32'h0000_0404);
        push_request(lfuc_pkg::CMD_PUT, 16'h0808, 32'h0000_0808);
        push_request(lfuc_pkg::CMD_PUT, 16'h1010, 32'h0000_1010);
        push_request(lfuc_pkg::CMD_PUT, 16'h2020, 32'h0000_2020);
        drain();
        write_capacity(5'd1);
        push_request(lfuc_pkg::CMD_PUT, 16'h4040, 32'h0000_4040);
        push_request(lfuc_pkg::CMD_GET, 16'h0101, 32'h0000_0000);
        push_request(lfuc_pkg::CMD_PUT, 16'h8080, 32'h0000_8080);
        drain();

        // capacity above the table size, no idling, with a long receiver hold
        write_capacity(5'd31);
        set_idling(0, 0);
        queue_random(250, 22);
        hold_go = 1;
        drain();

        write_capacity(5'd16);
        set_idling(57, 0);
        queue_random(200, 20);
        drain();

        write_capacity(5'd5);
        set_idling(0, 57);
        queue_random(200, 8);
        drain();

        write_capacity(5'd1);
        set_idling(36, 36);
        queue_random(150, 4);
        drain();

        write_capacity(5'd0);
        set_idling(36, 36);
        queue_random(50, 6);
        drain();

        write_capacity(5'd16);
        set_idling(36, 36);
        queue_random(150, 24);
        drain();

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
